// ----- hw/rtl/dsfr_pkg.sv -----
`default_nettype none

package dsfr_pkg;

	// Field widths of the byte and result channels
	localparam int BYTE_W = 8;
	localparam int STAT_W = 2;
	localparam int IDX_W  = 6;

	// Default frame buffer size
	localparam int FRAME_SIZE_DEF = 64;

	// Control characters on the line
	localparam logic [BYTE_W-1:0] FLAG_START = 8'hAA;
	localparam logic [BYTE_W-1:0] FLAG_ESC   = 8'h10;
	localparam logic [BYTE_W-1:0] FLAG_END   = 8'hFF;
	localparam logic [BYTE_W-1:0] FLAG_ACK   = 8'h30;

	// Status codes
	localparam logic [STAT_W-1:0] ST_DECODING = 2'd0;
	localparam logic [STAT_W-1:0] ST_ACK      = 2'd1;
	localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;
	localparam logic [STAT_W-1:0] ST_COMPLETE = 2'd3;

	// One decoded result
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic              data_valid;
		logic [BYTE_W-1:0] data_byte;
		logic [IDX_W-1:0]  data_index;
		logic [IDX_W-1:0]  frame_length;
	} dsfr_result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dsfr_in_stage.sv -----
`default_nettype none

module dsfr_in_stage
	import dsfr_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [BYTE_W-1:0] rx_byte,
	input  wire logic              advance,
	output logic                   valid_s1,
	output logic [BYTE_W-1:0]      byte_s1
);

	// Stage empties or moves on in the same cycle
	assign in_ready = !valid_s1 || advance;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Byte register, no reset
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/dsfr_decoder.sv -----
`default_nettype none

module dsfr_decoder
	import dsfr_pkg::*;
#(
	parameter int FRAME_SIZE = FRAME_SIZE_DEF
)
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire logic [BYTE_W-1:0] byte_s1,
	output dsfr_result_t           result
);

	// Count holds up to FRAME_SIZE-1 for the limit compare
	localparam int CNT_W = $clog2(FRAME_SIZE);
	localparam logic [CNT_W-1:0] LIMIT = CNT_W'(FRAME_SIZE - 1);

	logic             in_frame_q, in_frame_d;
	logic             esc_q, esc_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             store;
	logic             check;

	// Byte decode and next state
	always_comb begin
		result            = '0;
		result.status     = ST_DECODING;
		in_frame_d        = in_frame_q;
		esc_d             = esc_q;
		cnt_d             = cnt_q;
		store             = 1'b0;
		check             = 1'b1;

		if (esc_q) begin
			// literal byte after an escape
			esc_d = 1'b0;
			store = in_frame_q;
		end else if (byte_s1 == FLAG_START) begin
			cnt_d      = '0;
			in_frame_d = 1'b1;
		end else if (byte_s1 == FLAG_END) begin
			// reported even with no frame open
			in_frame_d          = 1'b0;
			result.status       = ST_COMPLETE;
			result.frame_length = IDX_W'(cnt_q);
			check               = 1'b0;
		end else if (byte_s1 == FLAG_ACK) begin
			result.status = ST_ACK;
			check         = 1'b0;
		end else if (byte_s1 == FLAG_ESC) begin
			esc_d = in_frame_q;
		end else begin
			store = in_frame_q;
		end

		if (store) begin
			result.data_valid = 1'b1;
			result.data_byte  = byte_s1;
			result.data_index = IDX_W'(cnt_q);
			cnt_d             = cnt_q + 1'b1;
		end

		// overflow: byte is still stored, count wraps, frame stays open
		if (check && cnt_d >= LIMIT) begin
			cnt_d         = '0;
			result.status = ST_OVERFLOW;
		end
	end

	// Frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			esc_q      <= 1'b0;
			cnt_q      <= '0;
		end else if (advance) begin
			in_frame_q <= in_frame_d;
			esc_q      <= esc_d;
			cnt_q      <= cnt_d;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/dsfr_out_stage.sv -----
`default_nettype none

module dsfr_out_stage
	import dsfr_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   valid_s1,
	input  wire dsfr_result_t result,
	output logic        advance,
	output logic        out_valid,
	input  wire logic   out_ready,
	output dsfr_result_t res_s2
);

	logic valid_s2;

	// Result register loads when empty or being drained
	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign out_valid = valid_s2;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	// Result payload, no reset
	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= result;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/dle_stuffed_frame_receiver.sv -----
// DLE byte-stuffed frame receiver.
// Input channel: in_valid/in_ready with rx_byte, one line byte per transfer.
// Output channel: out_valid/out_ready with status, data_valid, data_byte,
// data_index and frame_length; every input byte gives exactly one result.
// Control bytes: 0xAA opens a frame, 0xFF closes it (status frame complete,
// frame_length = payload count), 0x30 reports acknowledge, 0x10 inside a frame
// makes the next byte literal. Payload bytes come out with data_valid and their
// buffer index; when the count reaches FRAME_SIZE-1 status shows overflow and
// the count restarts at zero.
// Pipeline: each byte is held in the input register, then its result in the
// result register, which drives the outputs.
// Throughput: one byte per cycle while out_ready stays high, set by the single
// decode step between the two registers, which also updates the frame state.
// Reset (arst_n low) empties both registers, closes the frame, clears any
// pending escape and the count. When out_ready is low, the result register
// holds; the input register still takes one more byte, then in_ready drops
// until the result is taken.
`default_nettype none

module dle_stuffed_frame_receiver
	import dsfr_pkg::*;
#(
	parameter int FRAME_SIZE = FRAME_SIZE_DEF
)
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [BYTE_W-1:0] rx_byte,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [STAT_W-1:0]      status,
	output logic                   data_valid,
	output logic [BYTE_W-1:0]      data_byte,
	output logic [IDX_W-1:0]       data_index,
	output logic [IDX_W-1:0]       frame_length
);

	logic              advance;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	dsfr_result_t      result;
	dsfr_result_t      res_s2;

	dsfr_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	dsfr_decoder #(
		.FRAME_SIZE (FRAME_SIZE)
	) u_dec (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_s1 (byte_s1),
		.result  (result)
	);

	dsfr_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.result    (result),
		.advance   (advance),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_s2    (res_s2)
	);

	assign status       = res_s2.status;
	assign data_valid   = res_s2.data_valid;
	assign data_byte    = res_s2.data_byte;
	assign data_index   = res_s2.data_index;
	assign frame_length = res_s2.frame_length;

endmodule

`default_nettype wire

// ----- hw/rtl/dsfr_checker.sv -----
`default_nettype none

module dsfr_checker
	import dsfr_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [STAT_W-1:0] status,
	input wire logic              data_valid,
	input wire logic [BYTE_W-1:0] data_byte,
	input wire logic [IDX_W-1:0]  data_index,
	input wire logic [IDX_W-1:0]  frame_length
);

	// Stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
		&& $stable(data_valid) && $stable(data_byte) && $stable(data_index)
		&& $stable(frame_length))
		else $error("result changed while stalled");

	// Payload bytes only come with decoding or overflow status
	a_data_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && data_valid |-> status == ST_DECODING || status == ST_OVERFLOW)
		else $error("payload byte with control status");

	// Length is only reported on frame complete
	a_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_COMPLETE |-> frame_length == '0)
		else $error("frame_length set without completion");

	// Data fields are zero when no payload byte
	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !data_valid |-> data_byte == '0 && data_index == '0)
		else $error("data fields set without data_valid");

endmodule

bind dle_stuffed_frame_receiver dsfr_checker u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status       (status),
	.data_valid   (data_valid),
	.data_byte    (data_byte),
	.data_index   (data_index),
	.frame_length (frame_length)
);

`default_nettype wire

// ----- test/dle_stuffed_frame_receiver_tb.sv -----
`default_nettype none

module dle_stuffed_frame_receiver_tb
	import dsfr_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	logic [BYTE_W-1:0] rx_byte   = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [STAT_W-1:0] status;
	logic              data_valid;
	logic [BYTE_W-1:0] data_byte;
	logic [IDX_W-1:0]  data_index;
	logic [IDX_W-1:0]  frame_length;

	// Predicted frame state
	logic pr_in_frame;
	logic pr_escape;
	int   pr_count;

	dsfr_result_t decoded_q[$];
	dsfr_result_t want;

	// Idle control and hold-off request
	bit tx_idle_en = 1'b1;
	bit rx_idle_en = 1'b1;
	int rx_hold    = 0;
	int rx_gap;

	// Tallies
	int n_err      = 0;
	int n_sent     = 0;
	int n_checked  = 0;
	int n_overflow = 0;
	int n_complete = 0;
	int n_ack      = 0;
	int n_stored   = 0;

	dle_stuffed_frame_receiver i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.data_valid   (data_valid),
		.data_byte    (data_byte),
		.data_index   (data_index),
		.frame_length (frame_length)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Decode one line byte against the predicted state
	function automatic dsfr_result_t decode_byte(input logic [BYTE_W-1:0] b);
		dsfr_result_t r;
		logic         keep;
		logic         limit_on;
		r        = '0;
		r.status = ST_DECODING;
		keep     = 1'b0;
		limit_on = 1'b1;
		if (pr_escape) begin
			// escaped byte is literal whatever its value
			pr_escape = 1'b0;
			keep      = pr_in_frame;
		end else if (b == FLAG_START) begin
			pr_count    = 0;
			pr_in_frame = 1'b1;
		end else if (b == FLAG_END) begin
			// reported even with no frame open; count kept
			pr_in_frame    = 1'b0;
			r.status       = ST_COMPLETE;
			r.frame_length = pr_count[IDX_W-1:0];
			limit_on       = 1'b0;
		end else if (b == FLAG_ACK) begin
			r.status = ST_ACK;
			limit_on = 1'b0;
		end else if (b == FLAG_ESC) begin
			if (pr_in_frame)
				pr_escape = 1'b1;
		end else begin
			keep = pr_in_frame;
		end
		if (keep) begin
			r.data_valid = 1'b1;
			r.data_byte  = b;
			r.data_index = pr_count[IDX_W-1:0];
			pr_count++;
		end
		// byte that hits the limit is still stored
		if (limit_on && pr_count >= FRAME_SIZE_DEF - 1) begin
			pr_count = 0;
			r.status = ST_OVERFLOW;
		end
		return r;
	endfunction

	// Predict on each input transfer, check each output transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				decoded_q.push_back(decode_byte(rx_byte));
			if (out_valid && out_ready) begin
				if (decoded_q.size() == 0) begin
					$error("result with no byte pending: status %0d", status);
					n_err++;
				end else begin
					want = decoded_q.pop_front();
					n_checked++;
					if (status != want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						n_err++;
					end
					if (data_valid != want.data_valid) begin
						$error("data_valid: expected %0d, got %0d", want.data_valid, data_valid);
						n_err++;
					end
					if (data_byte != want.data_byte) begin
						$error("data_byte: expected %0h, got %0h", want.data_byte, data_byte);
						n_err++;
					end
					if (data_index != want.data_index) begin
						$error("data_index: expected %0d, got %0d", want.data_index, data_index);
						n_err++;
					end
					if (frame_length != want.frame_length) begin
						$error("frame_length: expected %0d, got %0d",
							want.frame_length, frame_length);
						n_err++;
					end
					case (want.status)
						ST_OVERFLOW: n_overflow++;
						ST_COMPLETE: n_complete++;
						ST_ACK:      n_ack++;
						default:     ;
					endcase
					if (want.data_valid)
						n_stored++;
				end
			end
		end
	end

	// Result side: random stalls, plus a long hold-off on request
	always begin
		@(negedge clk);
		if (rx_hold > 0) begin
			out_ready = 1'b0;
			repeat (rx_hold) @(negedge clk);
			rx_hold = 0;
		end
		rx_gap = rx_idle_en ? $urandom_range(0, 3) : 0;
		if (rx_gap > 0) begin
			out_ready = 1'b0;
			repeat (rx_gap) @(negedge clk);
		end
		out_ready = 1'b1;
		do @(posedge clk); while (!out_valid);
	end

	// One byte transfer on the input channel
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		gap = tx_idle_en ? $urandom_range(0, 3) : 0;
		repeat (gap) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid = 1'b1;
		rx_byte  = b;
		do @(posedge clk); while (!in_ready);
		n_sent++;
	endtask

	// Stop offering bytes until every predicted result has come out
	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [BYTE_W-1:0] plain_byte();
		logic [BYTE_W-1:0] b;
		b = BYTE_W'($urandom_range(0, 255));
		if (b == FLAG_START || b == FLAG_END || b == FLAG_ACK || b == FLAG_ESC)
			b = b ^ 8'h01;
		return b;
	endfunction

	function automatic logic [BYTE_W-1:0] ctrl_byte();
		logic [BYTE_W-1:0] b;
		case ($urandom_range(0, 3))
			0:       b = FLAG_START;
			1:       b = FLAG_END;
			2:       b = FLAG_ACK;
			default: b = FLAG_ESC;
		endcase
		return b;
	endfunction

	// Frame with random payload; control bytes mostly escaped
	task automatic send_frame(input int len, input bit close);
		logic [BYTE_W-1:0] b;
		send_byte(FLAG_START);
		for (int i = 0; i < len; i++) begin
			b = ($urandom_range(0, 5) == 0) ? ctrl_byte() : plain_byte();
			if (b == FLAG_ACK && $urandom_range(0, 1))
				send_byte(b);          // raw ack inside the frame
			else begin
				if (b == FLAG_START || b == FLAG_END || b == FLAG_ACK || b == FLAG_ESC)
					send_byte(FLAG_ESC);
				send_byte(b);
			end
		end
		if (close)
			send_byte(FLAG_END);
	endtask

	// Control bytes in and out of frames, extremes of the byte range
	task automatic test_directed();
		logic [BYTE_W-1:0] seq[$];
		seq = '{FLAG_END, FLAG_ACK, FLAG_ESC, FLAG_START, FLAG_ESC, 8'h55, FLAG_ACK,
			8'h00, 8'h7F, 8'h80, FLAG_ESC, FLAG_START, FLAG_ESC, FLAG_ESC,
			FLAG_ESC, FLAG_END, FLAG_ESC, FLAG_ACK, FLAG_END, FLAG_END,
			8'h01, FLAG_START, FLAG_START, 8'hFE, FLAG_END};
		foreach (seq[i])
			send_byte(seq[i]);
		wait_drained();
	endtask

	// Fill a frame to the limit, the last byte escaped, then keep going
	task automatic test_overflow();
		send_byte(FLAG_START);
		repeat (FRAME_SIZE_DEF - 2)
			send_byte(plain_byte());
		send_byte(FLAG_ESC);
		send_byte(FLAG_END);
		repeat (3)
			send_byte(plain_byte());
		send_byte(FLAG_END);
		// plain byte reaching the limit
		send_byte(FLAG_START);
		repeat (FRAME_SIZE_DEF + 5)
			send_byte(plain_byte());
		send_byte(FLAG_END);
		wait_drained();
	endtask

	// Receiver holds off while the sender keeps offering bytes
	task automatic test_backpressure();
		tx_idle_en = 1'b0;
		rx_hold    = 40;
		send_frame(14, 1'b1);
		tx_idle_en = 1'b1;
		wait_drained();
	endtask

	// Mostly well-formed frames, some noise and broken frames
	task automatic test_random();
		int sel;
		int len;
		bit paused;
		paused = 1'b0;
		while (n_sent < 600) begin
			tx_idle_en = ($urandom_range(0, 4) != 0);
			rx_idle_en = ($urandom_range(0, 4) != 0);
			sel = $urandom_range(0, 9);
			if (sel == 0) begin
				repeat ($urandom_range(1, 6))
					send_byte(BYTE_W'($urandom_range(0, 255)));
			end else if (sel == 1) begin
				// open frame ending in an escaped end flag, or closed by a plain end flag
				send_frame($urandom_range(0, 6), 1'b0);
				if ($urandom_range(0, 1))
					send_byte(FLAG_ESC);
				send_byte(FLAG_END);
			end else begin
				len = ($urandom_range(0, 6) == 0) ? $urandom_range(40, 80)
					: $urandom_range(0, 16);
				send_frame(len, 1'b1);
			end
			if (!paused && n_sent > 400) begin
				paused = 1'b1;
				wait_drained();
			end
		end
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	initial begin
		pr_in_frame = 1'b0;
		pr_escape   = 1'b0;
		pr_count    = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_overflow();
		test_backpressure();
		test_random();

		wait_drained();
		repeat (10) @(posedge clk);
		$display("Run: %0d bytes sent, %0d results checked, %0d payload bytes stored",
			n_sent, n_checked, n_stored);
		$display("Seen: %0d frames closed, %0d overflows, %0d acknowledges, %0d mismatches",
			n_complete, n_overflow, n_ack, n_err);
		if (n_err == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("Timeout with %0d results outstanding", decoded_q.size());
		$display("FAILED: results differ");
		$finish;
	end

endmodule

`default_nettype wire
